// File: rtl/hrg_pkg.sv
// Shared widths, codes and pipeline payload types for the HEALPix ring geometry block.
package hrg_pkg;

    localparam int RES_W     = 14;  // resolution register
    localparam int IDX_W     = 15;  // ring index and pixel position
    localparam int NPHI_W    = 16;  // ring pixel count
    localparam int START_W   = 30;  // ring-order first pixel
    localparam int LOG2_W    = 4;
    localparam int REGION_W  = 2;
    localparam int K_W       = 14;  // pixels per quadrant
    localparam int NUM_W     = 16;  // 2p+s
    localparam int DEN_W     = 17;  // 8k
    localparam int MUL_A_W   = 14;
    localparam int MUL_B_W   = 16;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int NSQ_W     = 27;  // nside squared, nside <= 8192

    // Quotient bits resolved by each divider stage
    localparam int DIV_BITS_PER_STG = 4;

    localparam logic [RES_W-1:0] MAX_NSIDE = 14'd8192;

    typedef enum logic [REGION_W-1:0] {
        REG_NORTH   = 2'd0,
        REG_EQUATOR = 2'd1,
        REG_SOUTH   = 2'd2
    } t_region;

    // Segment that selects the first-pixel formula
    typedef enum logic [1:0] {
        SEG_NORTH   = 2'd0,
        SEG_EQUATOR = 2'd1,
        SEG_SOUTH   = 2'd2
    } t_start_seg;

    typedef struct packed {
        logic [NPHI_W-1:0]  nphi;
        logic [START_W-1:0] start;
        logic               half;
        t_region            region;
        logic [LOG2_W-1:0]  log2;
        logic               bad_ring;
        logic               bad_pixel;
    } t_geom;

    typedef struct packed {
        t_geom               geom;
        t_start_seg          seg;
        logic [MUL_A_W-1:0]  mul_a;
        logic [MUL_B_W-1:0]  mul_b;
        logic [NUM_W-1:0]    num;
        logic [DEN_W-1:0]    den;
    } t_dec;

    typedef struct packed {
        t_geom               geom;
        t_start_seg          seg;
        logic [PROD_W-1:0]   prod;
        logic [NUM_W-1:0]    num;
        logic [DEN_W-1:0]    den;
    } t_mul;

endpackage

// File: rtl/hrg_ring_decode.sv
// Ring decode stage: region, quadrant size, shift, pixel count, range checks, multiplier operands.
module hrg_ring_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [hrg_pkg::IDX_W-1:0]  i_ring_index,
    input  logic [hrg_pkg::IDX_W-1:0]  i_pixel_in_ring,
    input  logic [hrg_pkg::RES_W-1:0]  i_nside,
    input  logic [hrg_pkg::LOG2_W-1:0] i_log2,
    output logic                       o_valid,
    output hrg_pkg::t_dec              o_dec
);
    import hrg_pkg::*;

    logic [15:0]      w_t, w_t1, w_p, w_n, w_four_n, w_three_n, w_r;
    logic [16:0]      w_two_t, w_eq_b;
    logic [K_W-1:0]   w_k;
    logic             w_half, w_bad_ring;
    t_region          w_region;
    logic [NPHI_W-1:0] w_nphi;
    t_dec             n_dec;
    logic             r_valid;
    t_dec             r_dec;

    // Common ring arithmetic
    assign w_t       = {1'b0, i_ring_index};
    assign w_t1      = w_t + 16'd1;
    assign w_p       = {1'b0, i_pixel_in_ring};
    assign w_n       = {2'b00, i_nside};
    assign w_four_n  = {i_nside, 2'b00};
    assign w_three_n = w_n + {1'b0, i_nside, 1'b0};
    assign w_r       = w_four_n - 16'd1 - w_t;
    assign w_two_t   = {1'b0, i_ring_index, 1'b0};
    assign w_eq_b    = w_two_t - {1'b0, w_n} + 17'd1;
    assign w_bad_ring = (w_t > (w_four_n - 16'd2));

    // Pick region, quadrant size and half-pixel shift
    always_comb begin
        if (w_t1 < w_n) begin
            w_region = REG_NORTH;
            w_k      = w_t1[K_W-1:0];
            w_half   = 1'b1;
        end else if (w_t1 <= w_three_n) begin
            w_region = REG_EQUATOR;
            w_k      = i_nside;
            w_half   = i_ring_index[0] ^ i_nside[0];
        end else begin
            w_region = REG_SOUTH;
            w_k      = w_r[K_W-1:0];
            w_half   = 1'b1;
        end
    end

    assign w_nphi = {w_k, 2'b00};

    // Assemble the decoded item, zeroing ring fields of a bad ring
    always_comb begin
        n_dec                = '0;
        n_dec.geom.bad_ring  = w_bad_ring;
        n_dec.geom.bad_pixel = !w_bad_ring && (w_p >= w_nphi);
        n_dec.geom.nphi      = w_bad_ring ? '0 : w_nphi;
        n_dec.geom.half      = w_bad_ring ? 1'b0 : w_half;
        n_dec.geom.region    = w_bad_ring ? REG_NORTH : w_region;
        n_dec.geom.log2      = w_bad_ring ? '0 : i_log2;
        n_dec.geom.start     = '0;
        n_dec.num            = {i_pixel_in_ring, w_half};
        n_dec.den            = {w_k, 3'b000};
        if (w_t < w_n) begin
            n_dec.seg   = SEG_NORTH;
            n_dec.mul_a = w_t[MUL_A_W-1:0];
            n_dec.mul_b = w_t1;
        end else if (w_t < w_three_n) begin
            n_dec.seg   = SEG_EQUATOR;
            n_dec.mul_a = i_nside;
            n_dec.mul_b = w_eq_b[MUL_B_W-1:0];
        end else begin
            n_dec.seg   = SEG_SOUTH;
            n_dec.mul_a = w_r[MUL_A_W-1:0];
            n_dec.mul_b = w_r + 16'd1;
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_dec <= n_dec;
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// File: rtl/hrg_ring_start.sv
// First-pixel stages: one product per item, then doubled and, for the south cap, mirrored from the total.
module hrg_ring_start (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  hrg_pkg::t_dec               i_dec,
    input  logic [hrg_pkg::START_W-1:0] i_total,
    output logic                        o_valid,
    output hrg_pkg::t_geom              o_geom,
    output logic [hrg_pkg::NUM_W-1:0]   o_num,
    output logic [hrg_pkg::DEN_W-1:0]   o_den
);
    import hrg_pkg::*;

    t_mul               n_mul;
    t_mul               r_mul;
    logic               r_mul_valid;
    logic [START_W-1:0] w_twice;
    logic [START_W-1:0] n_start;
    t_geom              n_geom;
    t_geom              r_geom;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic               r_valid;

    // Multiply the operands chosen by the decode stage
    always_comb begin
        n_mul      = '0;
        n_mul.geom = i_dec.geom;
        n_mul.seg  = i_dec.seg;
        n_mul.prod = {{MUL_B_W{1'b0}}, i_dec.mul_a} * {{MUL_A_W{1'b0}}, i_dec.mul_b};
        n_mul.num  = i_dec.num;
        n_mul.den  = i_dec.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else begin
            r_mul_valid <= i_valid;
        end
        r_mul <= n_mul;
    end

    // Double the product; mirror from the total for the south cap
    assign w_twice = {r_mul.prod[START_W-2:0], 1'b0};

    always_comb begin
        unique case (r_mul.seg)
            SEG_NORTH:   n_start = w_twice;
            SEG_EQUATOR: n_start = w_twice;
            SEG_SOUTH:   n_start = i_total - w_twice;
            default:     n_start = '0;
        endcase
        if (r_mul.geom.bad_ring) begin
            n_start = '0;
        end
    end

    // Merge the first pixel into the ring fields
    always_comb begin
        n_geom       = r_mul.geom;
        n_geom.start = n_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_mul_valid;
        end
        r_geom <= n_geom;
        r_num  <= r_mul.num;
        r_den  <= r_mul.den;
    end

    assign o_valid = r_valid;
    assign o_geom  = r_geom;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

// File: rtl/hrg_div_stage.sv
// One stage of the pipelined restoring divider for the azimuth fraction.
module hrg_div_stage #(
    parameter int PHASE_BITS = 32,
    parameter int STG        = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  hrg_pkg::t_geom            i_geom,
    input  logic [hrg_pkg::DEN_W-1:0] i_rem,
    input  logic [hrg_pkg::DEN_W-1:0] i_den,
    input  logic [PHASE_BITS-1:0]     i_quo,
    output logic                      o_valid,
    output hrg_pkg::t_geom            o_geom,
    output logic [hrg_pkg::DEN_W-1:0] o_rem,
    output logic [hrg_pkg::DEN_W-1:0] o_den,
    output logic [PHASE_BITS-1:0]     o_quo
);
    import hrg_pkg::*;

    localparam int FIRST = STG * DIV_BITS_PER_STG;

    logic [DEN_W:0]      w_sh;
    logic [DEN_W-1:0]    n_rem;
    logic [PHASE_BITS-1:0] n_quo;
    logic                r_valid;
    t_geom               r_geom;
    logic [DEN_W-1:0]    r_rem, r_den;
    logic [PHASE_BITS-1:0] r_quo;

    // Shift, trial-subtract and restore for this stage's quotient bits
    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        w_sh  = '0;
        for (int j = 0; j < DIV_BITS_PER_STG; j++) begin
            if (FIRST + j < PHASE_BITS) begin
                w_sh = {n_rem, 1'b0};
                if (w_sh >= {1'b0, i_den}) begin
                    w_sh  = w_sh - {1'b0, i_den};
                    n_quo = {n_quo[PHASE_BITS-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[PHASE_BITS-2:0], 1'b0};
                end
                n_rem = w_sh[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_geom <= i_geom;
        r_rem  <= n_rem;
        r_den  <= i_den;
        r_quo  <= n_quo;
    end

    assign o_valid = r_valid;
    assign o_geom  = r_geom;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quo   = r_quo;

endmodule

// File: rtl/healpix_ring_geometry_top.sv
// An accepted item passes through the decode, product, first-pixel and divider stage registers to its result strobe.
// Throughput: one item per cycle; decode, product, first-pixel and divider stages all advance
// every cycle, and the divider resolves four azimuth bits per stage.
// Results are strobed for one cycle each and cannot be held off.
// Reset (synchronous, active low) clears every valid bit, sets nside to 1, and holds busy
// high until the cycle after reset is released.
module healpix_ring_geometry_top #(
    parameter int PHASE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hrg_pkg::RES_W-1:0]    i_cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [hrg_pkg::IDX_W-1:0]    i_ring_index,
    input  logic [hrg_pkg::IDX_W-1:0]    i_pixel_in_ring,
    output logic                         o_strobe,
    output logic [hrg_pkg::NPHI_W-1:0]   o_ring_pixels,
    output logic [hrg_pkg::START_W-1:0]  o_ring_start,
    output logic [PHASE_BITS-1:0]        o_phase_turns,
    output logic                         o_half_shifted,
    output logic [hrg_pkg::REGION_W-1:0] o_ring_region,
    output logic [hrg_pkg::LOG2_W-1:0]   o_log2_resolution,
    output logic                         o_bad_ring,
    output logic                         o_bad_pixel
);
    import hrg_pkg::*;

    localparam int NDIV    = (PHASE_BITS + DIV_BITS_PER_STG - 1) / DIV_BITS_PER_STG;
    localparam int LAT_CYC = NDIV + 3;

    logic                r_ready;
    logic                w_accept;
    logic [RES_W-1:0]    n_nside, r_nside;
    logic [LOG2_W-1:0]   n_log2, r_log2;
    logic [NSQ_W-1:0]    r_nsq;
    logic [START_W-1:0]  r_total;
    logic [2*RES_W-1:0]  w_nsq_full;

    logic                w_dec_valid;
    t_dec                w_dec;

    logic                w_dv   [0:NDIV];
    t_geom               w_dg   [0:NDIV];
    logic [DEN_W-1:0]    w_drem [0:NDIV];
    logic [DEN_W-1:0]    w_dden [0:NDIV];
    logic [PHASE_BITS-1:0] w_dquo [0:NDIV];
    logic [NUM_W-1:0]    w_num;
    t_geom               w_out;

    // Accept items once out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign busy     = !r_ready;
    assign w_accept = start && r_ready;

    // Clamp the written resolution and find its highest set bit
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_nside = {{(RES_W-1){1'b0}}, 1'b1};
        end else if (i_cfg_wdata > MAX_NSIDE) begin
            n_nside = MAX_NSIDE;
        end else begin
            n_nside = i_cfg_wdata;
        end
        n_log2 = '0;
        for (int i = 0; i < RES_W; i++) begin
            if (n_nside[i]) begin
                n_log2 = LOG2_W'(i);
            end
        end
    end

    assign w_nsq_full = r_nside * r_nside;

    // Hold the resolution and derive 12*nside^2 through a registered nside squared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nside <= {{(RES_W-1){1'b0}}, 1'b1};
            r_log2  <= '0;
            r_nsq   <= {{(NSQ_W-1){1'b0}}, 1'b1};
            r_total <= START_W'(12);
        end else begin
            if (i_cfg_we) begin
                r_nside <= n_nside;
                r_log2  <= n_log2;
            end
            r_nsq   <= w_nsq_full[NSQ_W-1:0];
            r_total <= {r_nsq, 3'b000} + {1'b0, r_nsq, 2'b00};
        end
    end

    hrg_ring_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_accept),
        .i_ring_index    (i_ring_index),
        .i_pixel_in_ring (i_pixel_in_ring),
        .i_nside         (r_nside),
        .i_log2          (r_log2),
        .o_valid         (w_dec_valid),
        .o_dec           (w_dec)
    );

    hrg_ring_start u_start (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .i_dec   (w_dec),
        .i_total (r_total),
        .o_valid (w_dv[0]),
        .o_geom  (w_dg[0]),
        .o_num   (w_num),
        .o_den   (w_dden[0])
    );

    // Seed the divider with 2p+s as the running remainder
    assign w_drem[0] = {1'b0, w_num};
    assign w_dquo[0] = '0;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        hrg_div_stage #(
            .PHASE_BITS (PHASE_BITS),
            .STG        (g)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[g]),
            .i_geom  (w_dg[g]),
            .i_rem   (w_drem[g]),
            .i_den   (w_dden[g]),
            .i_quo   (w_dquo[g]),
            .o_valid (w_dv[g+1]),
            .o_geom  (w_dg[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_den   (w_dden[g+1]),
            .o_quo   (w_dquo[g+1])
        );
    end

    // Drive the result; drop the phase of a bad ring or pixel
    assign w_out             = w_dg[NDIV];
    assign o_strobe          = w_dv[NDIV];
    assign o_ring_pixels     = w_out.nphi;
    assign o_ring_start      = w_out.start;
    assign o_phase_turns     = (w_out.bad_ring || w_out.bad_pixel) ? '0 : w_dquo[NDIV];
    assign o_half_shifted    = w_out.half;
    assign o_ring_region     = w_out.region;
    assign o_log2_resolution = w_out.log2;
    assign o_bad_ring        = w_out.bad_ring;
    assign o_bad_pixel       = w_out.bad_pixel;

    // Every accepted transfer comes out as a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT_CYC o_strobe)
        else $error("result strobe missing after fixed latency");

    // A bad ring clears the whole result
    a_bad_ring_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_bad_ring) |-> (o_ring_pixels == '0 && o_ring_start == '0
            && o_phase_turns == '0 && !o_bad_pixel && o_log2_resolution == '0))
        else $error("bad ring result not cleared");

    // A valid ring has a non-zero pixel count that is a multiple of four
    a_ring_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_bad_ring) |-> (o_ring_pixels != '0 && o_ring_pixels[1:0] == 2'b00))
        else $error("ring pixel count malformed");

    // Polar rings are always half-pixel shifted
    a_polar_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_bad_ring && o_ring_region != REG_EQUATOR) |-> o_half_shifted)
        else $error("polar ring without half-pixel shift");

endmodule

// File: tb/tb_healpix_ring_geometry_top.sv
// Self-checking testbench for the HEALPix ring geometry block: predictor, scoreboard and stimulus.
`timescale 1ns / 100ps

module tb_healpix_ring_geometry_top;
    import hrg_pkg::*;

    typedef struct packed {
        logic [15:0] nphi;
        logic [29:0] start;
        logic [31:0] phase;
        logic        half;
        t_region     region;
        logic [3:0]  lg;
        logic        bad_ring;
        logic        bad_pixel;
    } t_ring_geom;

    // Hold the expected ring geometry per accepted transfer and compare results in order
    class t_ring_geom_tracker;
        logic [13:0] resolution;
        t_ring_geom  pending_geom[$];
        int          mismatches;

        function new();
            resolution = 14'd1;
            mismatches = 0;
        endfunction

        // Clamp the register to the nside that the geometry actually uses
        function int eff_nside();
            int n;
            n = resolution;
            if (n < 1) n = 1;
            if (n > 8192) n = 8192;
            return n;
        endfunction

        function t_ring_geom predict_geom(logic [14:0] t_in, logic [14:0] p_in);
            t_ring_geom      g;
            longint unsigned n, t, p, k, s, r, st, v;
            logic [63:0]     num;
            int              lg;
            g = '0;
            n = eff_nside();
            t = t_in;
            p = p_in;
            // Bad ring: flag only, every other field zero
            if (t > 4 * n - 2) begin
                g.bad_ring = 1'b1;
                return g;
            end
            if (t + 1 < n) begin
                g.region = REG_NORTH;
                k = t + 1;
                s = 1;
            end else if (t + 1 <= 3 * n) begin
                g.region = REG_EQUATOR;
                k = n;
                s = (t + n) & 1;
            end else begin
                g.region = REG_SOUTH;
                k = 4 * n - 1 - t;
                s = 1;
            end
            // First pixel of the ring in ring order
            if (t < n) begin
                st = 2 * t * (t + 1);
            end else if (t < 3 * n) begin
                st = 2 * n * (n + 1) + (t - n) * 4 * n;
            end else begin
                r  = 4 * n - 1 - t;
                st = 12 * n * n - 2 * r * (r + 1);
            end
            // Azimuth as exact truncated fraction of a turn; zero on a bad pixel
            if (p >= 4 * k) begin
                g.bad_pixel = 1'b1;
                g.phase     = '0;
            end else begin
                num     = 64'(2 * p + s) << 32;
                g.phase = 32'(num / (8 * k));
            end
            lg = 0;
            v  = n;
            while (v > 1) begin
                v = v >> 1;
                lg++;
            end
            g.nphi  = 16'(4 * k);
            g.start = 30'(st);
            g.half  = s[0];
            g.lg    = 4'(lg);
            return g;
        endfunction

        function void note_transfer(logic [14:0] t, logic [14:0] p);
            t_ring_geom g;
            g = predict_geom(t, p);
            pending_geom = {pending_geom, g};
        endfunction

        function int pending();
            return pending_geom.size();
        endfunction

        function void check_transfer(t_ring_geom act);
            t_ring_geom exp_g;
            if (pending_geom.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH: result with no transfer outstanding: nphi=%0d start=%0d",
                             act.nphi, act.start);
                return;
            end
            exp_g = pending_geom.pop_front();
            if (act.nphi !== exp_g.nphi || act.start !== exp_g.start
                    || act.phase !== exp_g.phase || act.half !== exp_g.half
                    || act.region !== exp_g.region || act.lg !== exp_g.lg
                    || act.bad_ring !== exp_g.bad_ring
                    || act.bad_pixel !== exp_g.bad_pixel) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("MISMATCH: exp nphi=%0d start=%0d phase=%h half=%0d reg=%0d lg=%0d br=%0d bp=%0d",
                             exp_g.nphi, exp_g.start, exp_g.phase, exp_g.half, exp_g.region,
                             exp_g.lg, exp_g.bad_ring, exp_g.bad_pixel);
                    $display("          act nphi=%0d start=%0d phase=%h half=%0d reg=%0d lg=%0d br=%0d bp=%0d",
                             act.nphi, act.start, act.phase, act.half, act.region,
                             act.lg, act.bad_ring, act.bad_pixel);
                end
            end
        endfunction
    endclass

    localparam int PHASE_BITS  = 32;
    localparam int LATENCY     = (PHASE_BITS + 3) / 4 + 3;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [13:0] i_cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [14:0] i_ring_index = '0;
    logic [14:0] i_pixel_in_ring = '0;
    logic        o_strobe;
    logic [15:0] o_ring_pixels;
    logic [29:0] o_ring_start;
    logic [31:0] o_phase_turns;
    logic        o_half_shifted;
    logic [1:0]  o_ring_region;
    logic [3:0]  o_log2_resolution;
    logic        o_bad_ring;
    logic        o_bad_pixel;

    t_ring_geom_tracker sb;
    int                 cycle_count = 0;
    bit                 allow_idle = 1'b1;

    healpix_ring_geometry_top #(
        .PHASE_BITS(PHASE_BITS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_ring_index      (i_ring_index),
        .i_pixel_in_ring   (i_pixel_in_ring),
        .o_strobe          (o_strobe),
        .o_ring_pixels     (o_ring_pixels),
        .o_ring_start      (o_ring_start),
        .o_phase_turns     (o_phase_turns),
        .o_half_shifted    (o_half_shifted),
        .o_ring_region     (o_ring_region),
        .o_log2_resolution (o_log2_resolution),
        .o_bad_ring        (o_bad_ring),
        .o_bad_pixel       (o_bad_pixel)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Capture each strobed result and check it against the oldest expectation
    always @(posedge i_clk) begin
        t_ring_geom act;
        if (i_rst_n && o_strobe) begin
            act.nphi      = o_ring_pixels;
            act.start     = o_ring_start;
            act.phase     = o_phase_turns;
            act.half      = o_half_shifted;
            act.region    = t_region'(o_ring_region);
            act.lg        = o_log2_resolution;
            act.bad_ring  = o_bad_ring;
            act.bad_pixel = o_bad_pixel;
            sb.check_transfer(act);
        end
    end

    // Present one item and hold it until the block takes the transfer
    task automatic send_item(logic [14:0] t, logic [14:0] p);
        @(negedge i_clk);
        start           = 1'b1;
        i_ring_index    = t;
        i_pixel_in_ring = p;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_transfer(t, p);
    endtask

    task automatic idle_cycles(int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write nside only once the pipeline is empty
    task automatic set_resolution(logic [13:0] v);
        wait_drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        sb.resolution = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Pick a ring and pixel: mostly valid geometry, some bad pixels, bad rings and noise
    task automatic pick_item(output logic [14:0] t, output logic [14:0] p);
        int n, last, tt, nphi, sel;
        int marks[9];
        t_ring_geom g0;
        n    = sb.eff_nside();
        last = 4 * n - 2;
        sel  = $urandom_range(0, 99);
        if (sel < 80) begin
            if ($urandom_range(0, 1) == 0) begin
                tt = $urandom_range(0, last);
            end else begin
                marks = '{0, n - 2, n - 1, n, 3 * n - 2, 3 * n - 1, 3 * n, 4 * n - 3, last};
                tt = marks[$urandom_range(0, 8)];
                if (tt < 0) tt = 0;
                if (tt > last) tt = last;
            end
            t    = 15'(tt);
            g0   = sb.predict_geom(t, '0);
            nphi = g0.nphi;
            if (sel < 70 || nphi > 32767) begin
                case ($urandom_range(0, 3))
                    0: p = '0;
                    1: p = 15'(nphi - 1);
                    default: p = 15'($urandom_range(0, nphi - 1));
                endcase
            end else begin
                p = 15'($urandom_range(nphi, 32767));
            end
        end else if (sel < 90) begin
            t = 15'($urandom_range(last + 1, 32767));
            p = 15'($urandom_range(0, 32767));
        end else begin
            t = 15'($urandom());
            p = 15'($urandom());
        end
    endtask

    task automatic run_random(int count);
        logic [14:0] t, p;
        repeat (count) begin
            pick_item(t, p);
            send_item(t, p);
            if (allow_idle && $urandom_range(0, 4) == 0)
                idle_cycles($urandom_range(1, 11));
        end
    endtask

    initial begin
        int res_list[17];
        sb = new();
        res_list = '{1, 2, 3, 4, 5, 7, 8, 13, 64, 100, 1024, 4095, 8191, 8192, 0, 16383, 0};

        // Hold reset, then release on a falling edge
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset nside of one, pixel and ring edges, all-ones inputs
        send_item(15'd0, 15'd0);
        send_item(15'd0, 15'd3);
        send_item(15'd0, 15'd4);
        send_item(15'd1, 15'd0);
        send_item(15'd2, 15'd3);
        send_item(15'd3, 15'd0);
        send_item(15'h7FFF, 15'h7FFF);
        // Zero register acts as nside one
        set_resolution(14'd0);
        send_item(15'd1, 15'd2);
        // Register above the maximum clamps to 8192
        set_resolution(14'h3FFF);
        send_item(15'd0, 15'd0);
        send_item(15'd8190, 15'd32763);
        send_item(15'd8190, 15'd32764);
        send_item(15'd8191, 15'h7FFF);
        send_item(15'd24575, 15'd0);
        send_item(15'd24576, 15'd5);
        send_item(15'd32766, 15'd3);
        send_item(15'd32766, 15'd4);
        send_item(15'h7FFF, 15'd0);
        // Odd nside: alternating shift across the belt
        set_resolution(14'd3);
        send_item(15'd1, 15'd7);
        send_item(15'd2, 15'd11);
        send_item(15'd3, 15'd0);
        send_item(15'd6, 15'd0);
        send_item(15'd8, 15'd3);
        send_item(15'd9, 15'd0);

        // Random phases across several resolutions, extremes included
        res_list[16] = $urandom_range(1, 8192);
        foreach (res_list[i]) begin
            set_resolution(14'(res_list[i]));
            run_random(100);
        end

        // Final stretch with no idling
        set_resolution(14'($urandom_range(1, 40)));
        allow_idle = 1'b0;
        run_random(150);

        // Drain and let the pipeline settle
        wait_drain();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/hrg_pkg.sv
rtl/hrg_ring_decode.sv
rtl/hrg_ring_start.sv
rtl/hrg_div_stage.sv
rtl/healpix_ring_geometry_top.sv
tb/tb_healpix_ring_geometry_top.sv
